/* sv/implicit_list_heap_allocator_macros.svh */
// Assertion macros shared by the allocator checker.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_MACROS_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define ILHA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("allocator check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define ILHA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

/* sv/ilha_pkg.sv */
// Shared types and constants of the implicit list heap allocator.
package ilha_pkg;

	localparam int HEAP_BYTES  = 65536;
	localparam int STORE_DEPTH = HEAP_BYTES / 4;
	localparam int IDX_W       = $clog2(STORE_DEPTH);
	localparam int AW          = 20;
	localparam int TAG_W       = 18;

	localparam logic [TAG_W-1:0] PAD_TAG = 18'h1BEEF;
	localparam logic [TAG_W-1:0] PRO_TAG = 18'h00009;
	localparam logic [TAG_W-1:0] EPI_TAG = 18'h00001;

	localparam logic [1:0] ST_ALLOC = 2'd0;
	localparam logic [1:0] ST_FAIL  = 2'd1;
	localparam logic [1:0] ST_FREED = 2'd2;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;

	localparam logic REG_FIT   = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	// Controller states.
	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE, S_A_INIT, S_A_NFST, S_W_CHK, S_W_EVAL, S_W_END,
		S_PL_W0, S_PL_W1, S_PL_W2, S_PL_W3,
		S_G_RD1, S_G_RD2, S_G_CHK, S_G_W0, S_G_W1, S_G_W2,
		S_F_CHK, S_F_HDR, S_F_FTR, S_F_W0, S_F_W1, S_F_RDN, S_F_RDP, S_F_MRG,
		S_F_W2, S_F_W3, S_FIN_OK, S_FIN_FAIL, S_FIN_FREE
	} state_t;

	// Datapath micro-operations.
	typedef enum logic [5:0] {
		OP_NOP, OP_CLEAR, OP_LATCH, OP_A_INIT, OP_A_NFST, OP_W_CHK, OP_W_EVAL, OP_W_END,
		OP_PL_W0, OP_PL_W1, OP_PL_W2, OP_PL_W3,
		OP_G_RD1, OP_G_RD2, OP_G_CHK, OP_G_W0, OP_G_W1, OP_G_W2,
		OP_F_CHK, OP_F_HDR, OP_F_FTR, OP_F_W0, OP_F_W1, OP_F_RDN, OP_F_RDP, OP_F_MRG,
		OP_F_W2, OP_F_W3, OP_FIN_OK, OP_FIN_FAIL, OP_FIN_FREE
	} op_t;

	// Status flags from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic req_free;
		logic zero_req;
		logic nf;
		logic bf;
		logic end_pass;
		logic w_zero;
		logic w_hit;
		logic pass1;
		logic found;
		logic split;
		logic g_fail;
		logic bad;
	} ilha_stat_t;

endpackage

/* sv/ilha_ctrl.sv */
// Controller state machine of the allocator.
module ilha_ctrl import ilha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ilha_stat_t stat,
	output op_t        op,
	output logic       busy
);

	state_t state_q, state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR:    if (stat.clr_last) state_nx = S_IDLE;
			S_IDLE: begin
				if (start) state_nx = stat.req_free ? S_F_CHK : S_A_INIT;
			end
			S_A_INIT: begin
				if (stat.zero_req) state_nx = S_FIN_FAIL;
				else if (stat.nf) state_nx = S_A_NFST;
				else state_nx = S_W_CHK;
			end
			S_A_NFST:   state_nx = S_W_CHK;
			S_W_CHK:    state_nx = stat.end_pass ? S_W_END : S_W_EVAL;
			S_W_EVAL: begin
				if (stat.w_zero) state_nx = S_W_END;
				else if (stat.w_hit && !stat.bf) state_nx = S_PL_W0;
				else state_nx = S_W_CHK;
			end
			S_W_END: begin
				if (stat.nf && !stat.pass1) state_nx = S_W_CHK;
				else if (stat.bf && stat.found) state_nx = S_PL_W0;
				else state_nx = S_G_RD1;
			end
			S_PL_W0:    state_nx = S_PL_W1;
			S_PL_W1:    state_nx = stat.split ? S_PL_W2 : S_FIN_OK;
			S_PL_W2:    state_nx = S_PL_W3;
			S_PL_W3:    state_nx = S_FIN_OK;
			S_G_RD1:    state_nx = S_G_RD2;
			S_G_RD2:    state_nx = S_G_CHK;
			S_G_CHK:    state_nx = stat.g_fail ? S_FIN_FAIL : S_G_W0;
			S_G_W0:     state_nx = S_G_W1;
			S_G_W1:     state_nx = S_G_W2;
			S_G_W2:     state_nx = S_FIN_OK;
			S_F_CHK:    state_nx = stat.bad ? S_FIN_FAIL : S_F_HDR;
			S_F_HDR:    state_nx = stat.bad ? S_FIN_FAIL : S_F_FTR;
			S_F_FTR:    state_nx = stat.bad ? S_FIN_FAIL : S_F_W0;
			S_F_W0:     state_nx = S_F_W1;
			S_F_W1:     state_nx = S_F_RDN;
			S_F_RDN:    state_nx = S_F_RDP;
			S_F_RDP:    state_nx = S_F_MRG;
			S_F_MRG:    state_nx = S_F_W2;
			S_F_W2:     state_nx = S_F_W3;
			S_F_W3:     state_nx = S_FIN_FREE;
			S_FIN_OK, S_FIN_FAIL, S_FIN_FREE: state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	// Command to the datapath.
	always_comb begin
		busy = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR:    op = OP_CLEAR;
			S_IDLE:     op = start ? OP_LATCH : OP_NOP;
			S_A_INIT:   op = OP_A_INIT;
			S_A_NFST:   op = OP_A_NFST;
			S_W_CHK:    op = OP_W_CHK;
			S_W_EVAL:   op = OP_W_EVAL;
			S_W_END:    op = OP_W_END;
			S_PL_W0:    op = OP_PL_W0;
			S_PL_W1:    op = OP_PL_W1;
			S_PL_W2:    op = OP_PL_W2;
			S_PL_W3:    op = OP_PL_W3;
			S_G_RD1:    op = OP_G_RD1;
			S_G_RD2:    op = OP_G_RD2;
			S_G_CHK:    op = OP_G_CHK;
			S_G_W0:     op = OP_G_W0;
			S_G_W1:     op = OP_G_W1;
			S_G_W2:     op = OP_G_W2;
			S_F_CHK:    op = OP_F_CHK;
			S_F_HDR:    op = OP_F_HDR;
			S_F_FTR:    op = OP_F_FTR;
			S_F_W0:     op = OP_F_W0;
			S_F_W1:     op = OP_F_W1;
			S_F_RDN:    op = OP_F_RDN;
			S_F_RDP:    op = OP_F_RDP;
			S_F_MRG:    op = OP_F_MRG;
			S_F_W2:     op = OP_F_W2;
			S_F_W3:     op = OP_F_W3;
			S_FIN_OK:   op = OP_FIN_OK;
			S_FIN_FAIL: op = OP_FIN_FAIL;
			S_FIN_FREE: op = OP_FIN_FREE;
			default:    op = OP_NOP;
		endcase
	end

endmodule

/* sv/ilha_dp.sv */
// Datapath of the allocator: tag memory, heap registers and tag arithmetic.
module ilha_dp import ilha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  op_t         op,
	input  logic        req_type,
	input  logic [16:0] req_size,
	input  logic [15:0] block_addr,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [16:0] cfg_wdata,
	output ilha_stat_t  stat,
	output logic        done,
	output logic [15:0] result_addr,
	output logic [1:0]  status
);

	// Tag memory, one word per four heap bytes.
	logic [TAG_W-1:0] mem [STORE_DEPTH];
	logic [TAG_W-1:0] rd_q;
	logic             rvld_q;

	// Control registers.
	logic [1:0]       fit_policy_q;
	logic [16:0]      heap_limit_q;
	logic [16:0]      heap_end_q;
	logic [15:0]      rover_q;
	logic [IDX_W-1:0] clr_idx_q;
	logic             done_q;

	// Working registers.
	logic [16:0]      req_size_q;
	logic [AW-1:0]    asize_q, p_q, start_q, bestp_q, best_q, osize_q, tsz_q, size_q, q_q;
	logic             pass_q, found_q;
	logic [TAG_W-1:0] hdr_q;
	logic [15:0]      res_addr_q;
	logic [1:0]       status_q;

	// Combinational values.
	logic [TAG_W-1:0] rdata, mwdata;
	logic [AW-1:0]    rd_size, rd_m8, end_a, lim_a, nsize, rsize, hsize;
	logic [AW-1:0]    avail, incr, room, curp, maddr, asz;
	logic [16:0]      lim17;
	logic             fits, better, split, tail_free, g_fail, bad, mwe, in_range;
	logic             nf, bf;

	function automatic logic [TAG_W-1:0] mk_tag(input logic [AW-1:0] sz, input logic a);
		mk_tag = {sz[TAG_W-1:1], a};
	endfunction

	// Tag fields and the arithmetic shared by the walk, growth and free steps.
	always_comb begin
		rdata     = rvld_q ? rd_q : '0;
		rd_size   = {{(AW-TAG_W){1'b0}}, rdata[TAG_W-1:3], 3'b000};
		rd_m8     = rd_size - AW'(8);
		end_a     = {{(AW-17){1'b0}}, heap_end_q};
		lim17     = (heap_limit_q < 17'(HEAP_BYTES)) ? heap_limit_q : 17'(HEAP_BYTES);
		lim_a     = {{(AW-17){1'b0}}, lim17};
		asz       = ({{(AW-17){1'b0}}, req_size_q} + AW'(7)) & ~AW'(7);
		nf        = (fit_policy_q == POL_NEXT);
		bf        = (fit_policy_q == POL_BEST);
		fits      = !rdata[0] && (rd_m8 >= asize_q);
		better    = !found_q || (rd_m8 < best_q);
		nsize     = asize_q + AW'(8);
		rsize     = osize_q - nsize;
		split     = (rsize >= AW'(8));
		hsize     = split ? nsize : osize_q;
		tail_free = (tsz_q != '0) && !rdata[0];
		avail     = tsz_q - AW'(8);
		incr      = tail_free ? (asize_q - avail) : nsize;
		room      = lim_a - end_a;
		g_fail    = (tail_free && (avail >= asize_q)) || (end_a > lim_a) || (incr > room);
		curp      = tail_free ? (end_a - tsz_q) : end_a;
	end

	// Request checks for free.
	always_comb begin
		case (op)
			OP_F_CHK: bad = (p_q[2:0] != 3'b000) || (p_q < AW'(16)) || (p_q >= end_a);
			OP_F_HDR: bad = !rdata[0] || (rd_size < AW'(8)) ||
				(rd_size > end_a - p_q + AW'(4));
			OP_F_FTR: bad = (rdata != hdr_q);
			default:  bad = 1'b0;
		endcase
	end

	// Status to the controller.
	always_comb begin
		stat.clr_last = (clr_idx_q == {IDX_W{1'b1}});
		stat.req_free = req_type;
		stat.zero_req = (req_size_q == '0);
		stat.nf       = nf;
		stat.bf       = bf;
		stat.end_pass = (p_q >= end_a) || (pass_q && (p_q >= start_q));
		stat.w_zero   = (rd_size == '0);
		stat.w_hit    = fits;
		stat.pass1    = pass_q;
		stat.found    = found_q;
		stat.split    = split;
		stat.g_fail   = g_fail;
		stat.bad      = bad;
	end

	// Memory address and write data for each step.
	always_comb begin
		maddr  = p_q - AW'(4);
		mwe    = 1'b0;
		mwdata = '0;
		case (op)
			OP_CLEAR: begin
				maddr = {{(AW-IDX_W-2){1'b0}}, clr_idx_q, 2'b00};
				mwe   = 1'b1;
				if (clr_idx_q == IDX_W'(0)) mwdata = PAD_TAG;
				else if (clr_idx_q == IDX_W'(1) || clr_idx_q == IDX_W'(2)) mwdata = PRO_TAG;
				else if (clr_idx_q == IDX_W'(3)) mwdata = EPI_TAG;
				else mwdata = '0;
			end
			OP_A_INIT: maddr = {{(AW-16){1'b0}}, rover_q} - AW'(4);
			OP_PL_W0: begin
				mwe = 1'b1; mwdata = mk_tag(hsize, 1'b1);
			end
			OP_PL_W1: begin
				maddr = p_q + hsize - AW'(8); mwe = 1'b1; mwdata = mk_tag(hsize, 1'b1);
			end
			OP_PL_W2: begin
				maddr = p_q + nsize - AW'(4); mwe = 1'b1; mwdata = mk_tag(rsize, 1'b0);
			end
			OP_PL_W3: begin
				maddr = p_q + osize_q - AW'(8); mwe = 1'b1; mwdata = mk_tag(rsize, 1'b0);
			end
			OP_G_RD1: maddr = end_a - AW'(8);
			OP_G_RD2: maddr = end_a - rd_size - AW'(4);
			OP_G_W0: begin
				mwe = 1'b1; mwdata = mk_tag(nsize, 1'b1);
			end
			OP_G_W1: begin
				maddr = p_q + asize_q; mwe = 1'b1; mwdata = mk_tag(nsize, 1'b1);
			end
			OP_G_W2: begin
				maddr = end_a - AW'(4); mwe = 1'b1; mwdata = EPI_TAG;
			end
			OP_F_HDR: maddr = p_q + rd_size - AW'(8);
			OP_F_W0: begin
				mwe = 1'b1; mwdata = mk_tag(size_q, 1'b0);
			end
			OP_F_W1: begin
				maddr = p_q + size_q - AW'(8); mwe = 1'b1; mwdata = mk_tag(size_q, 1'b0);
			end
			OP_F_RDN: maddr = p_q + size_q - AW'(4);
			OP_F_RDP: maddr = p_q - AW'(8);
			OP_F_W2: begin
				maddr = q_q - AW'(4); mwe = 1'b1; mwdata = mk_tag(size_q, 1'b0);
			end
			OP_F_W3: begin
				maddr = q_q + size_q - AW'(8); mwe = 1'b1; mwdata = mk_tag(size_q, 1'b0);
			end
			default: ;
		endcase
		in_range = (maddr[AW-1:IDX_W+2] == '0);
	end

	// Single-port tag memory; out-of-range reads return zero.
	always_ff @(posedge clk) begin
		if (mwe && in_range) mem[maddr[IDX_W+1:2]] <= mwdata;
		rd_q   <= mem[maddr[IDX_W+1:2]];
		rvld_q <= in_range;
	end

	// Heap state, configuration and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q <= POL_FIRST;
			heap_limit_q <= 17'(HEAP_BYTES);
			heap_end_q   <= 17'd16;
			rover_q      <= 16'd8;
			clr_idx_q    <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= (op == OP_FIN_OK) || (op == OP_FIN_FAIL) || (op == OP_FIN_FREE);
			if (op == OP_CLEAR) clr_idx_q <= clr_idx_q + IDX_W'(1);
			if (cfg_we && cfg_idx == REG_FIT) fit_policy_q <= cfg_wdata[1:0];
			if (cfg_we && cfg_idx == REG_LIMIT) heap_limit_q <= cfg_wdata;
			if (op == OP_G_CHK && !g_fail) heap_end_q <= 17'(end_a + incr);
			if (op == OP_FIN_OK) rover_q <= p_q[15:0];
			if (op == OP_FIN_FREE) rover_q <= q_q[15:0];
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		case (op)
			OP_LATCH: begin
				req_size_q <= req_size;
				p_q        <= {{(AW-16){1'b0}}, block_addr};
			end
			OP_A_INIT: begin
				asize_q <= asz;
				p_q     <= AW'(8);
				start_q <= '0;
				pass_q  <= 1'b0;
				found_q <= 1'b0;
			end
			OP_A_NFST: begin
				p_q     <= {{(AW-16){1'b0}}, rover_q} + rd_size;
				start_q <= {{(AW-16){1'b0}}, rover_q} + rd_size;
			end
			OP_W_EVAL: begin
				osize_q <= rd_size;
				if (fits && bf && better) begin
					best_q  <= rd_m8;
					bestp_q <= p_q;
					found_q <= 1'b1;
				end
				if (!(fits && !bf)) p_q <= p_q + rd_size;
			end
			OP_W_END: begin
				if (nf && !pass_q) begin
					p_q    <= AW'(8);
					pass_q <= 1'b1;
				end else if (bf && found_q) begin
					p_q     <= bestp_q;
					osize_q <= best_q + AW'(8);
				end
			end
			OP_G_RD2: tsz_q <= rd_size;
			OP_G_CHK: if (!g_fail) p_q <= curp;
			OP_F_HDR: begin
				hdr_q  <= rdata;
				size_q <= rd_size;
			end
			OP_F_RDP: begin
				if (!rdata[0]) size_q <= size_q + rd_size;
				q_q <= p_q;
			end
			OP_F_MRG: begin
				if (!rdata[0]) begin
					size_q <= size_q + rd_size;
					q_q    <= p_q - rd_size;
				end
			end
			OP_FIN_OK: begin
				res_addr_q <= p_q[15:0];
				status_q   <= ST_ALLOC;
			end
			OP_FIN_FAIL: begin
				res_addr_q <= '0;
				status_q   <= ST_FAIL;
			end
			OP_FIN_FREE: begin
				res_addr_q <= '0;
				status_q   <= ST_FREED;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign result_addr = res_addr_q;
	assign status      = status_q;

endmodule

/* sv/implicit_list_heap_allocator.sv */
// Implicit free list heap allocator with boundary tags, top level.
// After reset the block sweeps its 16384-word tag memory to lay out the
// initial heap, with busy high for the whole sweep; configuration
// writes are taken during that sweep. A request is taken when start is high
// and busy is low, and its result appears on done for one cycle; the
// receiver cannot stall, so the result must be captured in that cycle.
// A free checks the address, header and footer, refusing at the first fault,
// then writes the freed header and footer, reads both neighbours, merges the
// free ones and writes the merged tags. An allocate sets up (and steps past
// the rover's block under next fit), reads each block visited on the walk
// through the one-port tag memory, then places the block, splitting off a
// large enough rest, or grows the heap, which can fail; done is registered
// from the final state. Best fit and growth walk the whole list; next fit wraps round from the rover.
module implicit_list_heap_allocator import ilha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [16:0] req_size,
	input  logic [15:0] block_addr,
	output logic        done,
	output logic [15:0] result_addr,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [16:0] cfg_wdata
);

	op_t        op;
	ilha_stat_t stat;

	// Sequencer.
	ilha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	// Tag memory and heap arithmetic.
	ilha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.req_type    (req_type),
		.req_size    (req_size),
		.block_addr  (block_addr),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.stat        (stat),
		.done        (done),
		.result_addr (result_addr),
		.status      (status)
	);

endmodule

/* sv/ilha_checker.sv */
// Port-level checker of the allocator, bound to the top level.
`include "implicit_list_heap_allocator_macros.svh"

module ilha_checker import ilha_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [15:0] result_addr,
	input logic [1:0]  status
);

	// An accepted transaction keeps the block busy in the next cycle.
	`ILHA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

	// A result only follows a cycle of work.
	`ILHA_ASSERT_NOW(a_done_after_busy, done, $past(busy))

	// Only allocations return an address.
	`ILHA_ASSERT_NOW(a_addr_zero, done && status != ST_ALLOC, result_addr == 16'd0)

	// Allocated payloads are eight-byte aligned and past the prologue.
	`ILHA_ASSERT_NOW(a_addr_align, done && status == ST_ALLOC,
		result_addr[2:0] == 3'b000 && result_addr >= 16'd8)

	// Status codes stay within the defined set.
	`ILHA_ASSERT_NOW(a_status_code, done,
		status == ST_ALLOC || status == ST_FAIL || status == ST_FREED)

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (.*);
